/* rtl/core/lssd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lssd_pkg
// Shared types and constants for the LED strip serial driver.
// ----------------------------------------------------------------------------
package lssd_pkg;

  // Field widths
  localparam int unsigned TICK_W   = 12;
  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned COLOUR_W = 24;
  localparam int unsigned BITPOS_W = 5;
  localparam int unsigned BITS_PER_LED = 24;

  // Operation codes
  localparam logic [1:0] OP_SET_COLOUR = 2'd0;
  localparam logic [1:0] OP_START      = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ONE_HIGH  = 2'd0;
  localparam logic [1:0] REG_ONE_LOW   = 2'd1;
  localparam logic [1:0] REG_ZERO_HIGH = 2'd2;
  localparam logic [1:0] REG_ZERO_LOW  = 2'd3;

  // Reset values of the timing registers
  localparam logic [TICK_W-1:0] ONE_HIGH_RST  = 12'd700;
  localparam logic [TICK_W-1:0] ONE_LOW_RST   = 12'd600;
  localparam logic [TICK_W-1:0] ZERO_HIGH_RST = 12'd350;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST  = 12'd800;

  // Pulse timing set
  typedef struct packed {
    logic [TICK_W-1:0] one_high;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] zero_high;
    logic [TICK_W-1:0] zero_low;
  } timing_t;

  // Serializer status after one transaction
  typedef struct packed {
    logic line_level;
    logic busy;
    logic frame_done;
  } status_t;

endpackage

/* rtl/core/lssd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lssd_in_if / lssd_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface lssd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] led_number;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;

  modport source (output valid, operation, led_number, red_level, green_level,
                  blue_level, input ready);
  modport sink (input valid, operation, led_number, red_level, green_level,
                blue_level, output ready);
endinterface

interface lssd_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic frame_done;

  modport source (output valid, line_level, busy_res, frame_done, input ready);
  modport sink (input valid, line_level, busy_res, frame_done, output ready);
endinterface

/* rtl/core/lssd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lssd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lssd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] q_r;

  // Write port, read port returns old data on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    q_r <= mem_r[rd_addr];
  end

  assign rd_data = q_r;

endmodule

/* rtl/core/lssd_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lssd_store
// Colour store: RAM plus per-entry valid bits (unwritten entries read zero)
// and a forwarding path for a write to the entry being read.
// ----------------------------------------------------------------------------
module lssd_store #(
  parameter int unsigned LED_TOTAL = 8,
  parameter int unsigned AW = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [lssd_pkg::COLOUR_W-1:0] wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [lssd_pkg::COLOUR_W-1:0] rd_word
);

  logic [LED_TOTAL-1:0]          valid_r;
  logic                          vld_r;
  logic                          fwd_hit_r;
  logic [lssd_pkg::COLOUR_W-1:0] fwd_data_r;
  logic [lssd_pkg::COLOUR_W-1:0] ram_q;

  lssd_ram #(
    .WIDTH (lssd_pkg::COLOUR_W),
    .DEPTH (LED_TOTAL)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Track written entries and hold the forwarding data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      vld_r     <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      vld_r     <= valid_r[rd_addr];
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
    fwd_data_r <= wr_data;
  end

  // Select forwarded, stored or cleared word
  always_comb begin
    if (fwd_hit_r) begin
      rd_word = fwd_data_r;
    end else if (vld_r) begin
      rd_word = ram_q;
    end else begin
      rd_word = '0;
    end
  end

endmodule

/* rtl/core/lssd_ser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lssd_ser
// One-wire serializer: frame, LED, bit and phase counters.
// ----------------------------------------------------------------------------
module lssd_ser #(
  parameter int unsigned LED_TOTAL = 8,
  parameter int unsigned AW = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    operation,
  input  logic [lssd_pkg::COLOUR_W-1:0] word,
  input  lssd_pkg::timing_t             tmg,
  output logic [AW-1:0]                 led_pos_nxt,
  output lssd_pkg::status_t             status
);

  logic [AW-1:0]                 led_pos_r;
  logic [lssd_pkg::BITPOS_W-1:0] bit_pos_r, bit_pos_nxt;
  logic [lssd_pkg::TICK_W-1:0]   phase_r, phase_nxt;
  logic                          low_r, low_nxt;
  logic                          sending_r, sending_nxt;

  logic [lssd_pkg::BITPOS_W-1:0] bit_idx;
  logic                          cur_bit;
  logic [lssd_pkg::TICK_W-1:0]   limit;
  logic [lssd_pkg::TICK_W-1:0]   phase_inc;
  logic                          done;

  // Pick the bit being sent and the length of the current phase
  assign bit_idx   = lssd_pkg::BITPOS_W'(lssd_pkg::BITS_PER_LED - 1) - bit_pos_r;
  assign cur_bit   = word[bit_idx];
  assign phase_inc = phase_r + 1'b1;

  always_comb begin
    if (!low_r) begin
      limit = cur_bit ? tmg.one_high : tmg.zero_high;
    end else begin
      limit = cur_bit ? tmg.one_low : tmg.zero_low;
    end
  end

  // Advance the counters for one transaction
  always_comb begin
    led_pos_nxt = led_pos_r;
    bit_pos_nxt = bit_pos_r;
    phase_nxt   = phase_r;
    low_nxt     = low_r;
    sending_nxt = sending_r;
    done        = 1'b0;
    if (accept) begin
      case (operation)
        lssd_pkg::OP_START: begin
          if (!sending_r) begin
            sending_nxt = 1'b1;
            led_pos_nxt = '0;
            bit_pos_nxt = '0;
            phase_nxt   = '0;
            low_nxt     = 1'b0;
          end
        end
        lssd_pkg::OP_TICK: begin
          if (sending_r) begin
            phase_nxt = phase_inc;
            if (phase_inc >= limit) begin
              phase_nxt = '0;
              if (!low_r) begin
                low_nxt = 1'b1;
              end else begin
                low_nxt = 1'b0;
                if (bit_pos_r != lssd_pkg::BITPOS_W'(lssd_pkg::BITS_PER_LED - 1)) begin
                  bit_pos_nxt = bit_pos_r + 1'b1;
                end else begin
                  bit_pos_nxt = '0;
                  if (led_pos_r != AW'(LED_TOTAL - 1)) begin
                    led_pos_nxt = led_pos_r + 1'b1;
                  end else begin
                    led_pos_nxt = '0;
                    sending_nxt = 1'b0;
                    done        = 1'b1;
                  end
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_pos_r <= '0;
      bit_pos_r <= '0;
      phase_r   <= '0;
      low_r     <= 1'b0;
      sending_r <= 1'b0;
    end else begin
      led_pos_r <= led_pos_nxt;
      bit_pos_r <= bit_pos_nxt;
      phase_r   <= phase_nxt;
      low_r     <= low_nxt;
      sending_r <= sending_nxt;
    end
  end

  // Status after this transaction
  assign status.line_level = sending_nxt && !low_nxt;
  assign status.busy       = sending_nxt;
  assign status.frame_done = done;

endmodule

/* rtl/core/led_strip_serial_driver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_serial_driver_unit
// One-wire LED strip driver with a RAM-held colour store.
// ----------------------------------------------------------------------------
// The block takes one command per clock while its result register can take
// one (set colour, start frame, tick) and returns one result per command:
// line level, busy and frame-done. Each result is registered in the cycle
// after acceptance. The colour RAM read of the LED being sent is issued in the
// cycle before use, with a write to that same entry forwarded. The store needs
// no clearing pass: per-entry valid bits make an unwritten LED read as black
// right after reset. The user writes timing registers through the cfg port
// while no frame or command is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module led_strip_serial_driver_unit #(
  parameter int unsigned LED_TOTAL = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lssd_in_if.sink                     in_item,
  lssd_out_if.source                  out_res,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [lssd_pkg::TICK_W-1:0] cfg_data
);

  localparam int unsigned AW = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;

  lssd_pkg::timing_t             tmg_r;
  lssd_pkg::status_t             status;
  logic                          accept;
  logic                          in_range;
  logic                          wr_en;
  logic [AW-1:0]                 led_pos_nxt;
  logic [AW-1:0]                 rd_addr;
  logic [lssd_pkg::COLOUR_W-1:0] word;
  logic                          out_valid_r;
  lssd_pkg::status_t             out_stat_r;

  // Accept while the output register is empty or being drained
  assign in_item.ready = !out_valid_r || out_res.ready;
  assign accept        = in_item.valid && in_item.ready;

  // Drop colour writes beyond the strip
  assign in_range = {1'b0, in_item.led_number} < 9'(LED_TOTAL);
  assign wr_en    = accept && (in_item.operation == lssd_pkg::OP_SET_COLOUR) && in_range;
  assign rd_addr  = rst_n ? led_pos_nxt : '0;

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmg_r.one_high  <= lssd_pkg::ONE_HIGH_RST;
      tmg_r.one_low   <= lssd_pkg::ONE_LOW_RST;
      tmg_r.zero_high <= lssd_pkg::ZERO_HIGH_RST;
      tmg_r.zero_low  <= lssd_pkg::ZERO_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lssd_pkg::REG_ONE_HIGH:  tmg_r.one_high  <= cfg_data;
        lssd_pkg::REG_ONE_LOW:   tmg_r.one_low   <= cfg_data;
        lssd_pkg::REG_ZERO_HIGH: tmg_r.zero_high <= cfg_data;
        lssd_pkg::REG_ZERO_LOW:  tmg_r.zero_low  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lssd_store #(
    .LED_TOTAL (LED_TOTAL),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_addr (in_item.led_number[AW-1:0]),
    .wr_data ({in_item.green_level, in_item.red_level, in_item.blue_level}),
    .rd_addr (rd_addr),
    .rd_word (word)
  );

  lssd_ser #(
    .LED_TOTAL (LED_TOTAL),
    .AW        (AW)
  ) u_ser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .operation   (in_item.operation),
    .word        (word),
    .tmg         (tmg_r),
    .led_pos_nxt (led_pos_nxt),
    .status      (status)
  );

  // Output register: load on accept, clear when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
    if (accept) begin
      out_stat_r <= status;
    end
  end

  assign out_res.valid      = out_valid_r;
  assign out_res.line_level = out_stat_r.line_level;
  assign out_res.busy_res   = out_stat_r.busy;
  assign out_res.frame_done = out_stat_r.frame_done;

  // A finished frame is never reported as still busy
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> !(out_res.frame_done && out_res.busy_res))
    else $error("frame_done with busy set");

  // The line is only driven high inside a frame
  a_line_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.line_level |-> out_res.busy_res)
    else $error("line high while idle");

  // An accepted start always leaves the block busy
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_item.operation == lssd_pkg::OP_START) |=> out_stat_r.busy)
    else $error("start did not set busy");

  // Colour writes never reach an entry beyond the strip
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, in_item.led_number} < 9'(LED_TOTAL)))
    else $error("colour write out of range");

endmodule

/* tb/tb_led_strip_serial_driver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_led_strip_serial_driver_unit
// Self-checking bench for the LED strip serial driver. Set-colour, start and
// tick commands go in as bursts with random gaps while the result channel
// stalls on its own pattern. A line tracker keeps a copy of the colour store,
// the timing registers and the serializer position, and every result
// transaction is checked field by field against its prediction.
// ----------------------------------------------------------------------------
module tb_led_strip_serial_driver_unit;

  localparam int unsigned STRIP_LEDS    = 8;
  localparam int unsigned STALL_LIMIT   = 1000;  // cycles without any transaction
  localparam int unsigned SETTLE_CYCLES = 4;     // result is registered
  localparam int unsigned MIX_ITEMS     = 650;   // items sent before the long-timing run
  localparam int unsigned FINAL_TICKS   = 160;
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [lssd_pkg::TICK_W-1:0] TICK_MAX = {lssd_pkg::TICK_W{1'b1}};

  // Tracks the serializer and holds the status expected for each command
  class line_tracker;
    logic [lssd_pkg::COLOUR_W-1:0] colours [STRIP_LEDS];
    logic [7:0]                    led_pos;
    logic [lssd_pkg::BITPOS_W-1:0] bit_pos;
    logic [lssd_pkg::TICK_W-1:0]   phase_cnt;
    logic                          low_phase;
    logic                          sending;
    lssd_pkg::timing_t             timing;
    lssd_pkg::status_t             status_due [$];
    int unsigned                   mismatches;

    function new();
      foreach (colours[i]) colours[i] = '0;
      led_pos          = '0;
      bit_pos          = '0;
      phase_cnt        = '0;
      low_phase        = 1'b0;
      sending          = 1'b0;
      timing.one_high  = lssd_pkg::ONE_HIGH_RST;
      timing.one_low   = lssd_pkg::ONE_LOW_RST;
      timing.zero_high = lssd_pkg::ZERO_HIGH_RST;
      timing.zero_low  = lssd_pkg::ZERO_LOW_RST;
      mismatches       = 0;
    endfunction

    function void set_timing(logic [1:0] idx, logic [lssd_pkg::TICK_W-1:0] value);
      case (idx)
        lssd_pkg::REG_ONE_HIGH:  timing.one_high  = value;
        lssd_pkg::REG_ONE_LOW:   timing.one_low   = value;
        lssd_pkg::REG_ZERO_HIGH: timing.zero_high = value;
        lssd_pkg::REG_ZERO_LOW:  timing.zero_low  = value;
        default: ;
      endcase
    endfunction

    // Advance one tick; return 1 when the last low phase of the frame ends
    function logic advance_tick();
      logic [lssd_pkg::COLOUR_W-1:0] word;
      logic                          data_bit;
      logic [lssd_pkg::TICK_W-1:0]   limit;
      word = (led_pos < STRIP_LEDS) ? colours[led_pos] : '0;
      data_bit = word[lssd_pkg::BITS_PER_LED - 1 - bit_pos];
      if (!low_phase) begin
        limit = data_bit ? timing.one_high : timing.zero_high;
      end else begin
        limit = data_bit ? timing.one_low : timing.zero_low;
      end
      phase_cnt = phase_cnt + 1'b1;
      if (phase_cnt < limit) return 1'b0;
      phase_cnt = '0;
      if (!low_phase) begin
        low_phase = 1'b1;
        return 1'b0;
      end
      low_phase = 1'b0;
      if (bit_pos < lssd_pkg::BITS_PER_LED - 1) begin
        bit_pos = bit_pos + 1'b1;
        return 1'b0;
      end
      bit_pos = '0;
      if (led_pos < STRIP_LEDS - 1) begin
        led_pos = led_pos + 1'b1;
        return 1'b0;
      end
      led_pos = '0;
      sending = 1'b0;
      return 1'b1;
    endfunction

    // Apply an accepted command and queue the status it should produce
    function void note_command(logic [1:0] op, logic [7:0] led, logic [7:0] red,
                               logic [7:0] green, logic [7:0] blue);
      lssd_pkg::status_t s;
      s.frame_done = 1'b0;
      case (op)
        lssd_pkg::OP_SET_COLOUR: begin
          if (led < STRIP_LEDS) begin
            colours[led] = {green, red, blue};
          end
        end
        lssd_pkg::OP_START: begin
          if (!sending) begin
            sending   = 1'b1;
            led_pos   = '0;
            bit_pos   = '0;
            phase_cnt = '0;
            low_phase = 1'b0;
          end
        end
        lssd_pkg::OP_TICK: begin
          if (sending) begin
            s.frame_done = advance_tick();
          end
        end
        default: ;
      endcase
      s.line_level = sending && !low_phase;
      s.busy       = sending;
      status_due.push_back(s);
    endfunction

    // Compare one result transaction with the oldest expected status
    function void check_status(logic line, logic busy, logic done);
      lssd_pkg::status_t want;
      if (status_due.size() == 0) begin
        $display("%0t: result expected none actual line=%0b busy=%0b done=%0b",
                 $time, line, busy, done);
        mismatches++;
        return;
      end
      want = status_due.pop_front();
      if (line !== want.line_level) begin
        $display("%0t: line_level expected %0b actual %0b", $time, want.line_level, line);
        mismatches++;
      end
      if (busy !== want.busy) begin
        $display("%0t: busy_res expected %0b actual %0b", $time, want.busy, busy);
        mismatches++;
      end
      if (done !== want.frame_done) begin
        $display("%0t: frame_done expected %0b actual %0b", $time, want.frame_done, done);
        mismatches++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_we;
  logic [1:0]                  cfg_index;
  logic [lssd_pkg::TICK_W-1:0] cfg_data;

  lssd_in_if  in_ch ();
  lssd_out_if out_ch ();

  line_tracker tracker;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  int unsigned sent_items  = 0;

  led_strip_serial_driver_unit #(
    .LED_TOTAL (STRIP_LEDS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Send one command in the current burst; open a gap when the burst runs out
  task automatic send_item(input logic [1:0] op, input logic [7:0] led,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= op;
    in_ch.led_number  <= led;
    in_ch.red_level   <= red;
    in_ch.green_level <= green;
    in_ch.blue_level  <= blue;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.note_command(op, led, red, green, blue);
    sent_items++;
  endtask

  task automatic send_random(input logic [1:0] op);
    send_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (tracker.status_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [lssd_pkg::TICK_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    tracker.set_timing(idx, value);
    @(posedge clk);
  endtask

  // Finish any frame in flight, go idle, then load all four timing registers
  task automatic load_timing(input logic [lssd_pkg::TICK_W-1:0] one_high, one_low,
                             zero_high, zero_low);
    while (tracker.sending) send_random(lssd_pkg::OP_TICK);
    quiesce();
    write_reg(lssd_pkg::REG_ONE_HIGH, one_high);
    write_reg(lssd_pkg::REG_ONE_LOW, one_low);
    write_reg(lssd_pkg::REG_ZERO_HIGH, zero_high);
    write_reg(lssd_pkg::REG_ZERO_LOW, zero_low);
    cfg_we <= 1'b0;
  endtask

  // Short phases keep frames cheap; zero and one both mean a single tick
  function automatic logic [lssd_pkg::TICK_W-1:0] pick_ticks();
    if ($urandom_range(0, 9) == 0) return lssd_pkg::TICK_W'($urandom_range(2, 9));
    return lssd_pkg::TICK_W'($urandom_range(0, 1));
  endfunction

  // Favor the LED on the wire, then the rest of the strip, then any index
  function automatic logic [7:0] pick_led();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 3) return tracker.led_pos;
    if (roll < 8) return 8'($urandom_range(0, STRIP_LEDS - 1));
    return 8'($urandom);
  endfunction

  // Result channel: stall at a random rate that changes every stretch
  initial begin
    int unsigned span;
    int unsigned stall_pct;
    out_ch.ready <= 1'b0;
    span      = 0;
    stall_pct = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 85);
        span      = $urandom_range(16, 200);
      end
      span--;
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check results and watch for a hung handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        tracker.check_status(out_ch.line_level, out_ch.busy_res, out_ch.frame_done);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_led_strip_serial_driver_unit: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned roll;
    tracker = new();
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= lssd_pkg::REG_ONE_HIGH;
    cfg_data          <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.operation   <= lssd_pkg::OP_TICK;
    in_ch.led_number  <= '0;
    in_ch.red_level   <= '0;
    in_ch.green_level <= '0;
    in_ch.blue_level  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle behavior under reset timing: stray tick, unused code, store edges
    send_random(lssd_pkg::OP_TICK);
    send_random(OP_UNUSED);
    send_item(lssd_pkg::OP_SET_COLOUR, 8'd0, 8'h00, 8'hFF, 8'h00);
    send_item(lssd_pkg::OP_SET_COLOUR, 8'(STRIP_LEDS - 1), 8'hFF, 8'h00, 8'hFF);
    send_item(lssd_pkg::OP_SET_COLOUR, 8'(STRIP_LEDS), 8'hFF, 8'hFF, 8'hFF);
    send_item(lssd_pkg::OP_SET_COLOUR, 8'hFF, 8'hA5, 8'h5A, 8'hC3);
    send_random(lssd_pkg::OP_TICK);

    // Short frame with a zero high time; restart and recolor while busy
    load_timing(12'd2, 12'd1, 12'd0, 12'd1);
    send_random(lssd_pkg::OP_START);
    send_random(lssd_pkg::OP_START);
    send_random(lssd_pkg::OP_TICK);
    send_random(lssd_pkg::OP_TICK);
    send_random(OP_UNUSED);
    send_item(lssd_pkg::OP_SET_COLOUR, 8'd0, 8'h3C, 8'h00, 8'h81);
    repeat (3) send_random(lssd_pkg::OP_TICK);

    // Random phases: new timing, optional start, then mixed traffic
    while (sent_items < MIX_ITEMS) begin
      load_timing(pick_ticks(), pick_ticks(), pick_ticks(), pick_ticks());
      repeat ($urandom_range(0, 3)) begin
        send_item(lssd_pkg::OP_SET_COLOUR, pick_led(), 8'($urandom), 8'($urandom),
                  8'($urandom));
      end
      if ($urandom_range(0, 4) != 0) send_random(lssd_pkg::OP_START);
      repeat ($urandom_range(100, 300)) begin
        if (sent_items < MIX_ITEMS) begin
          roll = $urandom_range(0, 99);
          if (roll < 72) begin
            send_random(lssd_pkg::OP_TICK);
          end else if (roll < 88) begin
            send_item(lssd_pkg::OP_SET_COLOUR, pick_led(), 8'($urandom), 8'($urandom),
                      8'($urandom));
          end else if (roll < 95) begin
            send_random(lssd_pkg::OP_START);
          end else begin
            send_random(OP_UNUSED);
          end
        end
      end
    end

    // Longest one-bit timing: a zero bit completes, then a one bit holds high
    load_timing(TICK_MAX, TICK_MAX, 12'd40, 12'd60);
    send_item(lssd_pkg::OP_SET_COLOUR, 8'd0, 8'($urandom), 8'h40, 8'($urandom));
    send_random(lssd_pkg::OP_START);
    repeat (FINAL_TICKS) begin
      if ($urandom_range(0, 31) == 0) begin
        send_item(lssd_pkg::OP_SET_COLOUR, 8'($urandom_range(1, STRIP_LEDS - 1)),
                  8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        send_random(lssd_pkg::OP_TICK);
      end
    end

    quiesce();
    if (tracker.mismatches == 0) begin
      $display("tb_led_strip_serial_driver_unit: PASS");
    end else begin
      $display("tb_led_strip_serial_driver_unit: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/lssd_pkg.sv
rtl/core/lssd_if.sv
rtl/core/lssd_ram.sv
rtl/core/lssd_store.sv
rtl/core/lssd_ser.sv
rtl/core/led_strip_serial_driver_unit.sv
tb/tb_led_strip_serial_driver_unit.sv
